// ===== hdl/hsv_box_color_mask_core_defines.svh =====
// Assertion macros shared by the HSV box mask design.
`ifndef HSV_BOX_COLOR_MASK_CORE_DEFINES_SVH
`define HSV_BOX_COLOR_MASK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbcm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbcm: next-cycle check failed");

`endif

// ===== hdl/hbcm_pkg.sv =====
package hbcm_pkg;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    // Register indexes on the configuration port (address bits [4:2]).
    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    localparam logic [8:0] HUE_HIGH_RST = 9'd360;
    localparam logic [6:0] PCT_FULL     = 7'd100;

    localparam logic [7:0]  HUE_SEC     = 8'd60;
    localparam logic [7:0]  HUE_GREEN   = 8'd120;
    localparam logic [7:0]  HUE_BLUE    = 8'd240;
    localparam logic [8:0]  HUE_FULL    = 9'd360;
    localparam logic [12:0] VAL_RECIP   = 13'd5243;

    // Which channel holds the maximum; ties go blue, then green.
    typedef enum logic [1:0] {
        SEC_GRAY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // floor(pct * 256 / 100), done as pct * 5243 / 2048. The error stays
    // below one part in 25 over the whole 7-bit range, so it is exact.
    function automatic logic [8:0] val_limit(input logic [6:0] pct);
        logic [19:0] prod;
        prod = 20'(pct) * 20'(VAL_RECIP);
        return prod[19:11];
    endfunction

endpackage

// ===== hdl/hsv_box_color_mask_core.sv =====
// HSV box color mask. Each transaction on the input channel carries one BGR
// pixel; the pixel is converted to hue, saturation and value, tested against
// the HSV box held in the configuration registers, and comes out black with
// o_in_box set when it matches, unchanged otherwise. Hue and saturation are
// compared exactly by integer cross-multiplication. The datapath is a
// four-stage pipeline (channel max/min, products, hue wrap and saturation and
// value tests, hue test and output register), and one pixel is accepted
// every cycle while the output is not stalled. Write the registers only while
// no pixel is in flight.
`include "hsv_box_color_mask_core_defines.svh"

module hsv_box_color_mask_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hbcm_pkg::AddrW-1:0]  paddr,
    input  logic [hbcm_pkg::DataW-1:0]  pwdata,
    output logic [hbcm_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_blue_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_red_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_blue_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_red_out,
    output logic                        o_in_box
);
    import hbcm_pkg::*;

    // Configuration registers.
    logic [8:0] r_hue_low, r_hue_high;
    logic [6:0] r_sat_low, r_sat_high, r_val_low, r_val_high;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= '0;
            r_hue_high <= HUE_HIGH_RST;
            r_sat_low  <= '0;
            r_sat_high <= PCT_FULL;
            r_val_low  <= '0;
            r_val_high <= PCT_FULL;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_HUE_LOW:  r_hue_low  <= pwdata[8:0];
                REG_HUE_HIGH: r_hue_high <= pwdata[8:0];
                REG_SAT_LOW:  r_sat_low  <= pwdata[6:0];
                REG_SAT_HIGH: r_sat_high <= pwdata[6:0];
                REG_VAL_LOW:  r_val_low  <= pwdata[6:0];
                REG_VAL_HIGH: r_val_high <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_HUE_LOW:  prdata = DataW'(r_hue_low);
            REG_HUE_HIGH: prdata = DataW'(r_hue_high);
            REG_SAT_LOW:  prdata = DataW'(r_sat_low);
            REG_SAT_HIGH: prdata = DataW'(r_sat_high);
            REG_VAL_LOW:  prdata = DataW'(r_val_low);
            REG_VAL_HIGH: prdata = DataW'(r_val_high);
            default:      prdata = '0;
        endcase
    end

    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads.
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !r_v4 || !i_stall;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // Stage 1: max, min, spread and the hue sector.
    logic [7:0]        mx, mn;
    t_sector           sec;
    logic signed [8:0] diff;

    always_comb begin
        mx = i_blue_in;
        mn = i_blue_in;
        if (i_green_in > mx) mx = i_green_in;
        if (i_red_in > mx)   mx = i_red_in;
        if (i_green_in < mn) mn = i_green_in;
        if (i_red_in < mn)   mn = i_red_in;
        if (mx == mn) begin
            sec  = SEC_GRAY;
            diff = '0;
        end else if (i_blue_in == mx) begin
            sec  = SEC_BLUE;
            diff = $signed({1'b0, i_red_in}) - $signed({1'b0, i_green_in});
        end else if (i_green_in == mx) begin
            sec  = SEC_GREEN;
            diff = $signed({1'b0, i_blue_in}) - $signed({1'b0, i_red_in});
        end else begin
            sec  = SEC_RED;
            diff = $signed({1'b0, i_green_in}) - $signed({1'b0, i_blue_in});
        end
    end

    logic [7:0]        r_b1, r_g1, r_r1, r_mx1, r_d1;
    t_sector           r_sec1;
    logic signed [8:0] r_diff1;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_b1    <= i_blue_in;
            r_g1    <= i_green_in;
            r_r1    <= i_red_in;
            r_mx1   <= mx;
            r_d1    <= mx - mn;
            r_sec1  <= sec;
            r_diff1 <= diff;
        end
    end

    // Stage 2: hue numerator before wrap, and the cross products.
    logic [15:0]        base_d;
    logic signed [17:0] diff_ext, diff60, hsum;
    logic [7:0]         hden, sden;

    always_comb begin
        case (r_sec1)
            SEC_BLUE:  base_d = 16'(r_d1) * 16'(HUE_BLUE);
            SEC_GREEN: base_d = 16'(r_d1) * 16'(HUE_GREEN);
            default:   base_d = '0;
        endcase
        diff_ext = {{9{r_diff1[8]}}, r_diff1};
        diff60   = diff_ext * $signed({10'd0, HUE_SEC});
        hsum     = $signed({2'b00, base_d}) + diff60;
        // A gray pixel is compared as 0/1 for both hue and saturation.
        hden     = (r_sec1 == SEC_GRAY) ? 8'd1 : r_d1;
        sden     = (r_sec1 == SEC_GRAY) ? 8'd1 : r_mx1;
    end

    logic [7:0]         r_b2, r_g2, r_r2, r_mx2, r_d2;
    logic signed [17:0] r_hsum2;
    logic [14:0]        r_snum2, r_slo2, r_shi2;
    logic [16:0]        r_hlo2, r_hhi2;
    logic [8:0]         r_vlo2, r_vhi2;
    t_sector            r_sec2;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_b2    <= r_b1;
            r_g2    <= r_g1;
            r_r2    <= r_r1;
            r_mx2   <= r_mx1;
            r_d2    <= r_d1;
            r_sec2  <= r_sec1;
            r_hsum2 <= hsum;
            r_snum2 <= 15'(r_d1) * 15'(PCT_FULL);
            r_hlo2  <= 17'(r_hue_low) * 17'(hden);
            r_hhi2  <= 17'(r_hue_high) * 17'(hden);
            r_slo2  <= 15'(r_sat_low) * 15'(sden);
            r_shi2  <= 15'(r_sat_high) * 15'(sden);
            r_vlo2  <= val_limit(r_val_low);
            r_vhi2  <= val_limit(r_val_high);
        end
    end

    // Stage 3: wrap the hue into [0, 360*d), test saturation and value.
    logic signed [17:0] hwrap;

    always_comb begin
        if (r_hsum2 < 0) begin
            hwrap = r_hsum2 + $signed({1'b0, 17'(r_d2) * 17'(HUE_FULL)});
        end else begin
            hwrap = r_hsum2;
        end
    end

    logic [7:0]  r_b3, r_g3, r_r3;
    logic [16:0] r_hnum3, r_hlo3, r_hhi3;
    logic        r_sv_ok3, r_wrap3;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_b3     <= r_b2;
            r_g3     <= r_g2;
            r_r3     <= r_r2;
            r_hnum3  <= hwrap[16:0];
            r_hlo3   <= r_hlo2;
            r_hhi3   <= r_hhi2;
            r_wrap3  <= !(r_hue_high > r_hue_low);
            r_sv_ok3 <= (r_snum2 <= r_shi2) && (r_snum2 >= r_slo2)
                     && ({1'b0, r_mx2} <= r_vhi2) && ({1'b0, r_mx2} >= r_vlo2);
        end
    end

    // Stage 4: hue window test and the output register.
    logic hue_le, hue_ge, hue_ok, match;

    assign hue_le = r_hnum3 <= r_hhi3;
    assign hue_ge = r_hnum3 >= r_hlo3;
    assign hue_ok = r_wrap3 ? (hue_le || hue_ge) : (hue_le && hue_ge);
    assign match  = hue_ok && r_sv_ok3;

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            o_blue_out  <= match ? 8'd0 : r_b3;
            o_green_out <= match ? 8'd0 : r_g3;
            o_red_out   <= match ? 8'd0 : r_r3;
            o_in_box    <= match;
        end
    end

    `HBCM_ASSERT_SAME(a_masked_black, i_clk, i_rst_n, o_valid && o_in_box,
        o_blue_out == 8'd0 && o_green_out == 8'd0 && o_red_out == 8'd0)
    `HBCM_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && !o_stall, r_v1)
    `HBCM_ASSERT_SAME(a_gray_unsaturated, i_clk, i_rst_n,
        r_v2 && r_sec2 == SEC_GRAY, r_snum2 == 15'd0 && r_hsum2 == 18'sd0)
    `HBCM_ASSERT_NEXT(a_stalled_output_held, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_blue_out) && $stable(o_green_out) && $stable(o_red_out)
        && $stable(o_in_box))

endmodule
